>>> design/hue_color_fader_top_macros.svh
// Assertion macros used by the checker file of the hue color fader.
// No dependencies.
`ifndef HUE_COLOR_FADER_TOP_MACROS_SVH
`define HUE_COLOR_FADER_TOP_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define HCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define HCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> design/hcf_pkg.sv
// Package for the hue color fader: widths, register indexes, defaults, mul request, gamma table.
// No dependencies.
package hcf_pkg;
    localparam int unsigned LevelW = 8;
    localparam int unsigned HueW = 9;
    localparam int unsigned ProdW = 24;
    typedef enum logic [1:0] {
        t_REG_SAT = 2'd0,
        t_REG_VAL = 2'd1,
        t_REG_STEP = 2'd2,
        t_REG_NONE = 2'd3
    } t_reg_idx;
    localparam logic [LevelW-1:0] DefSat = 8'hFF;
    localparam logic [LevelW-1:0] DefVal = 8'hFF;
    localparam logic [LevelW-1:0] DefStep = 8'h01;

    // Control handed from the top level to the serial multiplier.
    typedef struct packed {
        logic start;
        logic [15:0] mcand;
        logic [7:0] mplier;
    } t_mul_req;

    function automatic logic [LevelW-1:0] gamma_duty(input logic [LevelW-1:0] lvl);
        logic [7:0] g;
        case (lvl)
            8'd0: g = 8'h00; 8'd1: g = 8'h00; 8'd2: g = 8'h01; 8'd3: g = 8'h01;
            8'd4: g = 8'h01; 8'd5: g = 8'h01; 8'd6: g = 8'h02; 8'd7: g = 8'h02;
            8'd8: g = 8'h02; 8'd9: g = 8'h02; 8'd10: g = 8'h03; 8'd11: g = 8'h03;
            8'd12: g = 8'h03; 8'd13: g = 8'h03; 8'd14: g = 8'h03; 8'd15: g = 8'h04;
            8'd16: g = 8'h04; 8'd17: g = 8'h04; 8'd18: g = 8'h05; 8'd19: g = 8'h05;
            8'd20: g = 8'h05; 8'd21: g = 8'h05; 8'd22: g = 8'h06; 8'd23: g = 8'h06;
            8'd24: g = 8'h06; 8'd25: g = 8'h06; 8'd26: g = 8'h07; 8'd27: g = 8'h07;
            8'd28: g = 8'h07; 8'd29: g = 8'h08; 8'd30: g = 8'h08; 8'd31: g = 8'h08;
            8'd32: g = 8'h08; 8'd33: g = 8'h09; 8'd34: g = 8'h09; 8'd35: g = 8'h09;
            8'd36: g = 8'h0A; 8'd37: g = 8'h0A; 8'd38: g = 8'h0A; 8'd39: g = 8'h0B;
            8'd40: g = 8'h0B; 8'd41: g = 8'h0B; 8'd42: g = 8'h0C; 8'd43: g = 8'h0C;
            8'd44: g = 8'h0C; 8'd45: g = 8'h0D; 8'd46: g = 8'h0D; 8'd47: g = 8'h0D;
            8'd48: g = 8'h0E; 8'd49: g = 8'h0E; 8'd50: g = 8'h0E; 8'd51: g = 8'h0F;
            8'd52: g = 8'h0F; 8'd53: g = 8'h0F; 8'd54: g = 8'h10; 8'd55: g = 8'h10;
            8'd56: g = 8'h11; 8'd57: g = 8'h11; 8'd58: g = 8'h11; 8'd59: g = 8'h12;
            8'd60: g = 8'h12; 8'd61: g = 8'h13; 8'd62: g = 8'h13; 8'd63: g = 8'h13;
            8'd64: g = 8'h14; 8'd65: g = 8'h14; 8'd66: g = 8'h15; 8'd67: g = 8'h15;
            8'd68: g = 8'h15; 8'd69: g = 8'h16; 8'd70: g = 8'h16; 8'd71: g = 8'h17;
            8'd72: g = 8'h17; 8'd73: g = 8'h18; 8'd74: g = 8'h18; 8'd75: g = 8'h19;
            8'd76: g = 8'h19; 8'd77: g = 8'h1A; 8'd78: g = 8'h1A; 8'd79: g = 8'h1A;
            8'd80: g = 8'h1B; 8'd81: g = 8'h1B; 8'd82: g = 8'h1C; 8'd83: g = 8'h1C;
            8'd84: g = 8'h1D; 8'd85: g = 8'h1D; 8'd86: g = 8'h1E; 8'd87: g = 8'h1E;
            8'd88: g = 8'h1F; 8'd89: g = 8'h20; 8'd90: g = 8'h20; 8'd91: g = 8'h21;
            8'd92: g = 8'h21; 8'd93: g = 8'h22; 8'd94: g = 8'h22; 8'd95: g = 8'h23;
            8'd96: g = 8'h23; 8'd97: g = 8'h24; 8'd98: g = 8'h25; 8'd99: g = 8'h25;
            8'd100: g = 8'h26; 8'd101: g = 8'h26; 8'd102: g = 8'h27; 8'd103: g = 8'h28;
            8'd104: g = 8'h28; 8'd105: g = 8'h29; 8'd106: g = 8'h29; 8'd107: g = 8'h2A;
            8'd108: g = 8'h2B; 8'd109: g = 8'h2B; 8'd110: g = 8'h2C; 8'd111: g = 8'h2D;
            8'd112: g = 8'h2D; 8'd113: g = 8'h2E; 8'd114: g = 8'h2F; 8'd115: g = 8'h2F;
            8'd116: g = 8'h30; 8'd117: g = 8'h31; 8'd118: g = 8'h31; 8'd119: g = 8'h32;
            8'd120: g = 8'h33; 8'd121: g = 8'h34; 8'd122: g = 8'h34; 8'd123: g = 8'h35;
            8'd124: g = 8'h36; 8'd125: g = 8'h37; 8'd126: g = 8'h37; 8'd127: g = 8'h38;
            8'd128: g = 8'h39; 8'd129: g = 8'h3A; 8'd130: g = 8'h3A; 8'd131: g = 8'h3B;
            8'd132: g = 8'h3C; 8'd133: g = 8'h3D; 8'd134: g = 8'h3E; 8'd135: g = 8'h3F;
            8'd136: g = 8'h3F; 8'd137: g = 8'h40; 8'd138: g = 8'h41; 8'd139: g = 8'h42;
            8'd140: g = 8'h43; 8'd141: g = 8'h44; 8'd142: g = 8'h45; 8'd143: g = 8'h46;
            8'd144: g = 8'h46; 8'd145: g = 8'h47; 8'd146: g = 8'h48; 8'd147: g = 8'h49;
            8'd148: g = 8'h4A; 8'd149: g = 8'h4B; 8'd150: g = 8'h4C; 8'd151: g = 8'h4D;
            8'd152: g = 8'h4E; 8'd153: g = 8'h4F; 8'd154: g = 8'h50; 8'd155: g = 8'h51;
            8'd156: g = 8'h52; 8'd157: g = 8'h53; 8'd158: g = 8'h54; 8'd159: g = 8'h55;
            8'd160: g = 8'h56; 8'd161: g = 8'h58; 8'd162: g = 8'h59; 8'd163: g = 8'h5A;
            8'd164: g = 8'h5B; 8'd165: g = 8'h5C; 8'd166: g = 8'h5D; 8'd167: g = 8'h5E;
            8'd168: g = 8'h5F; 8'd169: g = 8'h61; 8'd170: g = 8'h62; 8'd171: g = 8'h63;
            8'd172: g = 8'h64; 8'd173: g = 8'h65; 8'd174: g = 8'h67; 8'd175: g = 8'h68;
            8'd176: g = 8'h69; 8'd177: g = 8'h6A; 8'd178: g = 8'h6C; 8'd179: g = 8'h6D;
            8'd180: g = 8'h6E; 8'd181: g = 8'h70; 8'd182: g = 8'h71; 8'd183: g = 8'h72;
            8'd184: g = 8'h74; 8'd185: g = 8'h75; 8'd186: g = 8'h77; 8'd187: g = 8'h78;
            8'd188: g = 8'h79; 8'd189: g = 8'h7B; 8'd190: g = 8'h7C; 8'd191: g = 8'h7E;
            8'd192: g = 8'h7F; 8'd193: g = 8'h81; 8'd194: g = 8'h82; 8'd195: g = 8'h84;
            8'd196: g = 8'h85; 8'd197: g = 8'h87; 8'd198: g = 8'h88; 8'd199: g = 8'h8A;
            8'd200: g = 8'h8C; 8'd201: g = 8'h8D; 8'd202: g = 8'h8F; 8'd203: g = 8'h90;
            8'd204: g = 8'h92; 8'd205: g = 8'h94; 8'd206: g = 8'h96; 8'd207: g = 8'h97;
            8'd208: g = 8'h99; 8'd209: g = 8'h9B; 8'd210: g = 8'h9D; 8'd211: g = 8'h9E;
            8'd212: g = 8'hA0; 8'd213: g = 8'hA2; 8'd214: g = 8'hA4; 8'd215: g = 8'hA6;
            8'd216: g = 8'hA8; 8'd217: g = 8'hA9; 8'd218: g = 8'hAB; 8'd219: g = 8'hAD;
            8'd220: g = 8'hAF; 8'd221: g = 8'hB1; 8'd222: g = 8'hB3; 8'd223: g = 8'hB5;
            8'd224: g = 8'hB7; 8'd225: g = 8'hB9; 8'd226: g = 8'hBB; 8'd227: g = 8'hBE;
            8'd228: g = 8'hC0; 8'd229: g = 8'hC2; 8'd230: g = 8'hC4; 8'd231: g = 8'hC6;
            8'd232: g = 8'hC8; 8'd233: g = 8'hCB; 8'd234: g = 8'hCD; 8'd235: g = 8'hCF;
            8'd236: g = 8'hD1; 8'd237: g = 8'hD4; 8'd238: g = 8'hD6; 8'd239: g = 8'hD8;
            8'd240: g = 8'hDB; 8'd241: g = 8'hDD; 8'd242: g = 8'hE0; 8'd243: g = 8'hE2;
            8'd244: g = 8'hE5; 8'd245: g = 8'hE7; 8'd246: g = 8'hEA; 8'd247: g = 8'hEC;
            8'd248: g = 8'hEF; 8'd249: g = 8'hF2; 8'd250: g = 8'hF4; 8'd251: g = 8'hF7;
            8'd252: g = 8'hFA; 8'd253: g = 8'hFC; 8'd254: g = 8'hFF; default: g = 8'hFF;
        endcase
        return 8'hFF - g;
    endfunction
endpackage

>>> design/hue_color_fader_top.sv
// Top level of the hue color fader: handshakes, conversion sequencer, fade step.
// Depends on hcf_pkg and hcf_serial_mul.
// A tick transaction passes S_FIN and S_OUT before its result is registered; a hue
// transaction first runs three multiply passes (S_PREP, then S_MUL and S_WAIT per pass).
// Only one item is in work at a time and no input is taken while a result waits.
// Synchronous active-low reset restores control, configuration, levels and targets.
module hue_color_fader_top import hcf_pkg::*; #(
    parameter logic [7:0] P_DEF_SAT = DefSat,
    parameter logic [7:0] P_DEF_VAL = DefVal,
    parameter logic [7:0] P_DEF_STEP = DefStep
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [8:0] hue, rest zero
    input  logic        s_axis_tuser,  // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // {duty_blue, duty_green, duty_red}
    output logic        m_axis_tlast,  // fade_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_WAIT, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0] r_sat, r_val, r_step;
    logic [7:0] r_lvl [3];
    logic [7:0] r_tgt [3];
    logic [2:0] r_fall, r_arr;
    logic [1:0] r_phase;
    logic r_act;
    logic [2:0] r_sector;
    logic [5:0] r_rem;
    logic [1:0] r_pass;
    logic [7:0] r_c [3];
    logic r_done_flag;
    logic [23:0] r_out;
    logic r_out_last;
    logic r_ovalid;

    t_mul_req mreq;
    logic mul_done;
    logic [ProdW-1:0] mul_prod;

    hcf_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq),
        .o_done(mul_done), .o_prod(mul_prod)
    );

    // Pass 0: V*(255-S), divided by 255. Pass 1 and 2: V*(15300-S*x), over 15300.
    // S*x (x up to 60) fits a small multiply of narrow values.
    logic [13:0] s_times_x;
    logic [5:0] x_sel;
    always_comb begin
        x_sel = (r_pass == 2'd1) ? r_rem : 6'(7'd60 - {1'b0, r_rem});
        s_times_x = 14'(r_sat) * 14'(x_sel);
        mreq.start = (r_state == S_MUL);
        mreq.mplier = r_val;
        if (r_pass == 2'd0) mreq.mcand = {8'd0, 8'hFF - r_sat};
        else mreq.mcand = 16'(15'd15300 - {1'b0, s_times_x});
    end

    // Exact floor division by constants via reciprocal multiply and correction:
    // product < 2^22; q = (p*K)>>n then fix up by one.
    logic [7:0] quo;
    logic [21:0] p;
    logic [7:0] q0;
    logic [21:0] qd;
    always_comb begin
        p = mul_prod[21:0];
        if (r_pass == 2'd0) begin
            q0 = 8'(p >> 8);
            qd = 22'(q0 * 16'd255);
            if (p - qd >= 22'd255) quo = q0 + 8'd1; else quo = q0;
        end else begin
            q0 = 8'((31'(p) * 31'd274) >> 22);
            qd = 22'(q0) * 22'd15300;
            quo = (p - qd >= 22'd15300) ? q0 + 8'd1 : q0;
        end
    end

    // Fade step on the active channel.
    logic [1:0] ch;
    logic [8:0] up, dn;
    logic [7:0] nl;
    logic narr;
    always_comb begin
        ch = (r_phase == 2'd3) ? 2'd0 : r_phase;
        up = {1'b0, r_lvl[ch]} + {1'b0, r_step};
        dn = {1'b0, r_lvl[ch]} - {1'b0, r_step};
        nl = r_lvl[ch];
        narr = r_arr[ch];
        if (!r_arr[ch]) begin
            if (r_fall[ch]) begin
                if (dn[8] || dn[7:0] <= r_tgt[ch]) begin
                    nl = r_tgt[ch]; narr = 1'b1;
                end else nl = dn[7:0];
            end else begin
                if (up >= {1'b0, r_tgt[ch]}) begin
                    nl = r_tgt[ch]; narr = 1'b1;
                end else nl = up[7:0];
            end
        end
    end

    logic [8:0] hue_in;
    assign hue_in = s_axis_tdata[8:0];
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;
    assign m_axis_tlast = r_out_last;

    logic [7:0] rgb [3];
    always_comb begin
        if (r_sat == 8'd0) begin
            rgb[0] = r_val; rgb[1] = r_val; rgb[2] = r_val;
        end else begin
            case (r_sector)
                3'd0: begin rgb[0] = r_val; rgb[1] = r_c[2]; rgb[2] = r_c[0]; end
                3'd1: begin rgb[0] = r_c[1]; rgb[1] = r_val; rgb[2] = r_c[0]; end
                3'd2: begin rgb[0] = r_c[0]; rgb[1] = r_val; rgb[2] = r_c[2]; end
                3'd3: begin rgb[0] = r_c[0]; rgb[1] = r_c[1]; rgb[2] = r_val; end
                3'd4: begin rgb[0] = r_c[2]; rgb[1] = r_c[0]; rgb[2] = r_val; end
                default: begin rgb[0] = r_val; rgb[1] = r_c[0]; rgb[2] = r_c[1]; end
            endcase
        end
    end

    logic [8:0] h;
    always_comb h = (hue_in >= 9'd360) ? hue_in - 9'd360 : hue_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sat <= P_DEF_SAT; r_val <= P_DEF_VAL; r_step <= P_DEF_STEP;
            r_lvl[0] <= 8'h00; r_lvl[1] <= 8'h88; r_lvl[2] <= 8'hE7;
            r_tgt[0] <= 8'h00; r_tgt[1] <= 8'h88; r_tgt[2] <= 8'hE7;
            r_fall <= '0; r_arr <= 3'b111; r_phase <= '0;
            r_ovalid <= 1'b0; r_pass <= '0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_reg_idx'(i_cfg_index))
                    t_REG_SAT: r_sat <= i_cfg_data;
                    t_REG_VAL: r_val <= i_cfg_data;
                    t_REG_STEP: r_step <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_act <= s_axis_tuser;
                    // Sector by compare chain on a narrow value.
                    r_sector <= (h >= 9'd300) ? 3'd5 : (h >= 9'd240) ? 3'd4 :
                                (h >= 9'd180) ? 3'd3 : (h >= 9'd120) ? 3'd2 :
                                (h >= 9'd60) ? 3'd1 : 3'd0;
                    r_rem <= 6'((h >= 9'd300) ? h - 9'd300 : (h >= 9'd240) ? h - 9'd240 :
                                (h >= 9'd180) ? h - 9'd180 : (h >= 9'd120) ? h - 9'd120 :
                                (h >= 9'd60) ? h - 9'd60 : h);
                    r_pass <= '0;
                    r_state <= s_axis_tuser ? S_FIN : S_PREP;
                end
                S_PREP: r_state <= S_MUL;
                S_MUL: r_state <= S_WAIT;
                S_WAIT: if (mul_done) begin
                    r_c[r_pass] <= quo;
                    if (r_pass == 2'd2) r_state <= S_FIN;
                    else begin
                        r_pass <= r_pass + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (!r_act) begin
                        r_tgt[0] <= rgb[0]; r_tgt[1] <= rgb[1]; r_tgt[2] <= rgb[2];
                        r_fall <= {r_lvl[2] > rgb[2], r_lvl[1] > rgb[1], r_lvl[0] > rgb[0]};
                        r_arr <= '0; r_phase <= '0;
                        r_done_flag <= 1'b0;
                    end else begin
                        r_lvl[ch] <= nl;
                        r_arr[ch] <= narr;
                        r_done_flag <= (ch == 2'd2) && narr && r_arr[0] && r_arr[1];
                        r_phase <= (ch == 2'd2) ? 2'd0 : ch + 2'd1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out <= {gamma_duty(r_lvl[2]), gamma_duty(r_lvl[1]),
                              gamma_duty(r_lvl[0])};
                    r_out_last <= r_done_flag;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> design/hcf_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on hcf_pkg.
module hcf_serial_mul import hcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_req         i_req,
    output logic             o_done,
    output logic [ProdW-1:0] o_prod
);
    logic [ProdW-1:0] r_acc, n_acc;
    logic [ProdW-1:0] r_mc, n_mc;
    logic [7:0] r_mp, n_mp;
    logic [3:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_acc = r_acc; n_mc = r_mc; n_mp = r_mp; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_acc = '0;
            n_mc = {8'd0, i_req.mcand};
            n_mp = i_req.mplier;
            n_cnt = 4'd8;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_mp[0]) n_acc = r_acc + r_mc;
            n_mc = {r_mc[ProdW-2:0], 1'b0};
            n_mp = {1'b0, r_mp[7:1]};
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        r_mc <= n_mc;
        r_mp <= n_mp;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

>>> design/hcf_checker.sv
// Port-level checker for the hue color fader, bound to the top level.
// Depends on hue_color_fader_top_macros.svh.
`include "hue_color_fader_top_macros.svh"
module hcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `HCF_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}), "result changed while stalled")
    `HCF_ASSERT_IMP(a_no_take, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "input taken while a result waits")
    `HCF_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second input taken during work")
endmodule
bind hue_color_fader_top hcf_checker u_chk (.*);

>>> tb/sv/hue_color_fader_top_tb.sv
// Self-checking testbench for the hue color fader top level.
// Depends on hcf_pkg and the RTL of hue_color_fader_top; models fades and duties itself.
`timescale 1ns / 100ps

module hue_color_fader_top_tb import hcf_pkg::*;;

    localparam int unsigned IdleLimit = 20000;
    localparam logic ActHue = 1'b0;
    localparam logic ActTick = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = t_REG_NONE;
    logic [7:0]  i_cfg_data = '0;

    // One result: three PWM compare values and the fade-done flag.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
    } duty_t;

    duty_t duty_queue[$];
    int unsigned fail_count = 0;
    int unsigned sent_count = 0;
    int unsigned got_count = 0;
    int unsigned done_count = 0;
    int unsigned idle_cycles = 0;
    bit hold_sink = 1'b0;
    bit stim_done = 1'b0;

    // Predictor state: configuration, levels, targets and fade progress.
    logic [7:0] sat_reg, val_reg, step_reg;
    logic [7:0] level[3];
    logic [7:0] target[3];
    logic [2:0] falling, arrived;
    logic [1:0] phase;

    // The gamma table, kept in the testbench so the check does not borrow RTL logic.
    logic [7:0] gamma_tab[256];
    initial begin
        logic [7:0] g[256];
        g = '{
            8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h02,8'h02,8'h03,8'h03,8'h03,8'h03,
            8'h03,8'h04,8'h04,8'h04,8'h05,8'h05,8'h05,8'h05,8'h06,8'h06,8'h06,8'h06,8'h07,8'h07,
            8'h07,8'h08,8'h08,8'h08,8'h08,8'h09,8'h09,8'h09,8'h0A,8'h0A,8'h0A,8'h0B,8'h0B,8'h0B,
            8'h0C,8'h0C,8'h0C,8'h0D,8'h0D,8'h0D,8'h0E,8'h0E,8'h0E,8'h0F,8'h0F,8'h0F,8'h10,8'h10,
            8'h11,8'h11,8'h11,8'h12,8'h12,8'h13,8'h13,8'h13,8'h14,8'h14,8'h15,8'h15,8'h15,8'h16,
            8'h16,8'h17,8'h17,8'h18,8'h18,8'h19,8'h19,8'h1A,8'h1A,8'h1A,8'h1B,8'h1B,8'h1C,8'h1C,
            8'h1D,8'h1D,8'h1E,8'h1E,8'h1F,8'h20,8'h20,8'h21,8'h21,8'h22,8'h22,8'h23,8'h23,8'h24,
            8'h25,8'h25,8'h26,8'h26,8'h27,8'h28,8'h28,8'h29,8'h29,8'h2A,8'h2B,8'h2B,8'h2C,8'h2D,
            8'h2D,8'h2E,8'h2F,8'h2F,8'h30,8'h31,8'h31,8'h32,8'h33,8'h34,8'h34,8'h35,8'h36,8'h37,
            8'h37,8'h38,8'h39,8'h3A,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h3F,8'h40,8'h41,8'h42,
            8'h43,8'h44,8'h45,8'h46,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,
            8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h58,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,
            8'h5F,8'h61,8'h62,8'h63,8'h64,8'h65,8'h67,8'h68,8'h69,8'h6A,8'h6C,8'h6D,8'h6E,8'h70,
            8'h71,8'h72,8'h74,8'h75,8'h77,8'h78,8'h79,8'h7B,8'h7C,8'h7E,8'h7F,8'h81,8'h82,8'h84,
            8'h85,8'h87,8'h88,8'h8A,8'h8C,8'h8D,8'h8F,8'h90,8'h92,8'h94,8'h96,8'h97,8'h99,8'h9B,
            8'h9D,8'h9E,8'hA0,8'hA2,8'hA4,8'hA6,8'hA8,8'hA9,8'hAB,8'hAD,8'hAF,8'hB1,8'hB3,8'hB5,
            8'hB7,8'hB9,8'hBB,8'hBE,8'hC0,8'hC2,8'hC4,8'hC6,8'hC8,8'hCB,8'hCD,8'hCF,8'hD1,8'hD4,
            8'hD6,8'hD8,8'hDB,8'hDD,8'hE0,8'hE2,8'hE5,8'hE7,8'hEA,8'hEC,8'hEF,8'hF2,8'hF4,8'hF7,
            8'hFA,8'hFC,8'hFF,8'hFF};
        gamma_tab = g;
    end

    hue_color_fader_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Short gaps are common, long ones rare.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Converts a hue into RGB targets with exact integer arithmetic.
    function automatic void convert_hue_targets(input logic [8:0] hue_in);
        int unsigned h, v, s, sec, rem, c1, c2, c3;
        h = hue_in;
        if (h >= 360) h -= 360;
        v = val_reg;
        s = sat_reg;
        if (s == 0) begin
            target[0] = 8'(v); target[1] = 8'(v); target[2] = 8'(v);
            return;
        end
        sec = h / 60;
        rem = h % 60;
        c1 = (v * (255 - s)) / 255;
        c2 = (v * (15300 - s * rem)) / 15300;
        c3 = (v * (15300 - s * (60 - rem))) / 15300;
        case (sec)
            0: begin target[0] = 8'(v);  target[1] = 8'(c3); target[2] = 8'(c1); end
            1: begin target[0] = 8'(c2); target[1] = 8'(v);  target[2] = 8'(c1); end
            2: begin target[0] = 8'(c1); target[1] = 8'(v);  target[2] = 8'(c3); end
            3: begin target[0] = 8'(c1); target[1] = 8'(c2); target[2] = 8'(v);  end
            4: begin target[0] = 8'(c3); target[1] = 8'(c1); target[2] = 8'(v);  end
            default: begin target[0] = 8'(v); target[1] = 8'(c1); target[2] = 8'(c2); end
        endcase
    endfunction

    // Advances the fader model by one input and returns the duties it causes.
    function automatic duty_t predict_duties(input logic act, input logic [8:0] hue_in);
        duty_t d;
        int lvl, tgt, ch;
        d.done = 1'b0;
        if (act == ActHue) begin
            convert_hue_targets(hue_in);
            for (int k = 0; k < 3; k++) falling[k] = level[k] > target[k];
            arrived = '0;
            phase = 2'd0;
        end else begin
            ch = (phase <= 2) ? phase : 0;
            if (!arrived[ch]) begin
                lvl = level[ch];
                tgt = target[ch];
                if (falling[ch]) begin
                    lvl -= step_reg;
                    if (lvl <= tgt) begin lvl = tgt; arrived[ch] = 1'b1; end
                end else begin
                    lvl += step_reg;
                    if (lvl >= tgt) begin lvl = tgt; arrived[ch] = 1'b1; end
                end
                level[ch] = lvl[7:0];
            end
            d.done = (ch == 2) && (arrived == 3'b111);
            phase = 2'((ch + 1) % 3);
        end
        d.red = 8'hFF - gamma_tab[level[0]];
        d.green = 8'hFF - gamma_tab[level[1]];
        d.blue = 8'hFF - gamma_tab[level[2]];
        return d;
    endfunction

    // Offers one item after a random gap and records its expected duties.
    // Valid stays up after the handshake until the next call or a drain replaces it.
    task automatic send_item(input logic act, input logic [8:0] hue_in);
        int unsigned n;
        n = gap_len();
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {7'd0, hue_in};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        duty_queue.push_back(predict_duties(act, hue_in));
        sent_count++;
    endtask

    // Writes one register; the caller guarantees the fader is idle.
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            t_REG_SAT: sat_reg = value;
            t_REG_VAL: val_reg = value;
            t_REG_STEP: step_reg = value;
            default: ;
        endcase
    endtask

    // Waits until every expected result has been taken, then a short margin.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] v, input logic [7:0] st);
        drain_results();
        write_reg(t_REG_SAT, s);
        write_reg(t_REG_VAL, v);
        write_reg(t_REG_STEP, st);
        i_cfg_valid <= 1'b0;
    endtask

    // Directed: extreme hues, every sector, hue wrap above 359, grey and zero step.
    task automatic test_directed();
        send_item(ActTick, 9'd0);   // Ticks on the idle reset color.
        send_item(ActTick, 9'h1FF);
        send_item(ActTick, 9'd0);
        send_item(ActHue, 9'd0);
        for (int k = 0; k < 6; k++) send_item(ActTick, 9'h155);
        send_item(ActHue, 9'd511);  // Wraps once to 151.
        send_item(ActHue, 9'd360);
        send_item(ActHue, 9'd359);
        for (int s = 1; s < 6; s++) send_item(ActHue, 9'(s * 60 + 17));
        set_config(8'd0, 8'd255, 8'd255);
        send_item(ActHue, 9'd200);
        for (int k = 0; k < 4; k++) send_item(ActTick, 9'd0);
        set_config(8'd255, 8'd0, 8'd0);
        send_item(ActHue, 9'd42);
        for (int k = 0; k < 4; k++) send_item(ActTick, 9'd0);
    endtask

    // A fade: one hue and enough ticks to usually finish, with stray noise.
    task automatic run_fade(input int unsigned ticks);
        send_item(ActHue, 9'($urandom_range(0, 511)));
        for (int k = 0; k < ticks; k++)
            send_item(ActTick, 9'($urandom_range(0, 511)));
    endtask

    task automatic test_random_fades();
        int unsigned n;
        logic [7:0] st;
        for (int p = 0; p < 8; p++) begin
            st = (p == 0) ? 8'd255 : (p == 1) ? 8'd1 : 8'($urandom_range(16, 255));
            set_config(p == 2 ? 8'd0 : 8'($urandom_range(0, 255)),
                       p == 3 ? 8'd255 : 8'($urandom_range(0, 255)), st);
            n = 0;
            while (n < 150) begin
                int unsigned t;
                t = (st == 1) ? $urandom_range(3, 30) : $urandom_range(3, 30);
                if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 2);
                run_fade(t);
                n += t + 1;
            end
        end
    endtask

    // The sink stalls for a long stretch while the sender keeps offering items.
    task automatic test_back_pressure();
        hold_sink = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            run_fade(20);
        join
    endtask

    // Result sink with random stalls, checking each transaction field by field.
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        duty_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red = m_axis_tdata[7:0];
            got.green = m_axis_tdata[15:8];
            got.blue = m_axis_tdata[23:16];
            got.done = m_axis_tlast;
            got_count++;
            if (duty_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = duty_queue.pop_front();
                if (got.red !== want.red)
                    $display("%0t: duty_red expected %h actual %h", $time, want.red, got.red);
                if (got.green !== want.green)
                    $display("%0t: duty_green expected %h actual %h", $time, want.green,
                             got.green);
                if (got.blue !== want.blue)
                    $display("%0t: duty_blue expected %h actual %h", $time, want.blue, got.blue);
                if (got.done !== want.done)
                    $display("%0t: fade_done expected %b actual %b", $time, want.done, got.done);
                if (got !== want) fail_count++;
                if (want.done) done_count++;
            end
        end
        if (hold_sink) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!stim_done && $urandom_range(0, 3) == 0) begin
            stall_left <= gap_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any accepted transaction ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("[hue_color_fader_top] ERROR");
            $finish;
        end
    end

    initial begin
        sat_reg = DefSat; val_reg = DefVal; step_reg = DefStep;
        level = '{8'h00, 8'h88, 8'hE7};
        target = '{8'h00, 8'h88, 8'hE7};
        falling = '0; arrived = 3'b111; phase = 2'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_pressure();
        test_random_fades();
        stim_done = 1'b1;
        drain_results();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items and checked %0d results; %0d fades reported done.",
                 sent_count, got_count, done_count);
        if (fail_count == 0 && duty_queue.size() == 0)
            $display("[hue_color_fader_top] OK");
        else
            $display("[hue_color_fader_top] ERROR");
        $finish;
    end
endmodule
